@@ rtl/alfp_pkg.sv @@
// Package for the activity LED fader: request codes, sizes and level helpers.
`default_nettype none

package alfp_pkg;

  localparam int NUM_PORTS = 4;
  localparam int NCH       = NUM_PORTS + 1;
  localparam int LED_W     = 5;

  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_RX_BLINK  = 3'd1;
  localparam logic [2:0] REQ_TX_BLINK  = 3'd2;
  localparam logic [2:0] REQ_RST_BLINK = 3'd3;
  localparam logic [2:0] REQ_USB_OFF   = 3'd4;

  localparam logic [15:0] LOAD_LEVEL   = 16'h8000;
  localparam logic [15:0] RELOAD_BELOW = 16'h2000;
  localparam logic [15:0] BREATH_START = 16'h2000;
  localparam logic [15:0] BREATH_LIMIT = 16'hDFFF;
  localparam logic [15:0] FADE_STEP    = 16'd4;

  typedef logic [15:0] level_t;

  function automatic logic tri_compare(input level_t level);
    logic [7:0] p;
    logic [8:0] p2;
    p = level[15:8];
    if (p > 8'd254) p = 8'd254;
    if (p > 8'd127) p = 8'd254 - p;
    p2 = {p, 1'b0};
    return ({1'b0, level[7:0]} <= p2);
  endfunction

  function automatic level_t fade_down(input level_t level);
    return (level >= FADE_STEP) ? level - FADE_STEP : 16'd0;
  endfunction

endpackage

`default_nettype wire

@@ rtl/activity_led_fade_pwm_top.sv @@
// Activity LED fader top level: event handling, channel fading and result register.
// Latency: a tick beat gives its result beat in the cycle after it is accepted.
// Throughput: one beat per cycle; all channel levels update in parallel in one pass.
// Other request types give no result beat; blink and USB-off requests update state only, spare codes change nothing.
// While a result waits untaken the input stalls; a new beat enters as the result leaves.
// Reset (rst_n low, synchronous) clears all levels and drives; breathing restarts at 0x2000.
`default_nettype none

module activity_led_fade_pwm_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // port [2:0], button_held [3], zero [7:4]
  input  wire logic [2:0]  in_tuser,   // req_type [2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // power_led [0], rx_leds [5:1], tx_leds [10:6], zero
);

  alfp_pkg::level_t breath_r, breath_nxt;
  alfp_pkg::level_t rst_fade_r, rst_fade_nxt;
  alfp_pkg::level_t rx_fade_r [alfp_pkg::NCH];
  alfp_pkg::level_t rx_fade_nxt [alfp_pkg::NCH];
  alfp_pkg::level_t tx_fade_r [alfp_pkg::NCH];
  alfp_pkg::level_t tx_fade_nxt [alfp_pkg::NCH];
  logic [alfp_pkg::NCH-1:0] rx_drive_r, rx_drive_nxt;
  logic [alfp_pkg::NCH-1:0] tx_drive_r, tx_drive_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [10:0] out_data_r, out_data_nxt;

  logic       accept;
  logic [2:0] req;
  logic [2:0] port;
  logic       held;
  logic       power;
  logic [alfp_pkg::LED_W-1:0] rx_leds, tx_leds;
  alfp_pkg::level_t breath_inc;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign req        = in_tuser;
  assign port       = in_tdata[2:0];
  assign held       = in_tdata[3];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};
  assign breath_inc = breath_r + 16'd1;

  always_comb begin
    breath_nxt    = breath_r;
    rst_fade_nxt  = rst_fade_r;
    rx_fade_nxt   = rx_fade_r;
    tx_fade_nxt   = tx_fade_r;
    rx_drive_nxt  = rx_drive_r;
    tx_drive_nxt  = tx_drive_r;
    power         = 1'b0;
    rx_leds       = '0;
    tx_leds       = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (accept) begin
      unique case (req)
        alfp_pkg::REQ_TICK: begin
          breath_nxt = (breath_inc >= alfp_pkg::BREATH_LIMIT) ?
                       alfp_pkg::BREATH_START : breath_inc;
          if (held) begin
            power        = alfp_pkg::tri_compare(rst_fade_r);
            rst_fade_nxt = alfp_pkg::fade_down(rst_fade_r);
          end else begin
            power = alfp_pkg::tri_compare(breath_nxt);
          end
          for (int c = 0; c < alfp_pkg::NCH; c++) begin
            if (rx_fade_r[c] != 16'd0) begin
              rx_drive_nxt[c] = alfp_pkg::tri_compare(rx_fade_r[c]);
              rx_fade_nxt[c]  = alfp_pkg::fade_down(rx_fade_r[c]);
            end
            if (tx_fade_r[c] != 16'd0) begin
              tx_drive_nxt[c] = alfp_pkg::tri_compare(tx_fade_r[c]);
              tx_fade_nxt[c]  = alfp_pkg::fade_down(tx_fade_r[c]);
            end
          end
          for (int b = 0; b < alfp_pkg::LED_W; b++) begin
            if (b < alfp_pkg::NCH) begin
              rx_leds[b] = rx_drive_nxt[b];
              tx_leds[b] = tx_drive_nxt[b];
            end
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {tx_leds, rx_leds, power};
        end
        alfp_pkg::REQ_RX_BLINK: begin
          for (int c = 0; c < alfp_pkg::NCH; c++) begin
            if (int'(port) == c && rx_fade_r[c] < alfp_pkg::RELOAD_BELOW) begin
              rx_fade_nxt[c] = alfp_pkg::LOAD_LEVEL;
            end
          end
        end
        alfp_pkg::REQ_TX_BLINK: begin
          for (int c = 0; c < alfp_pkg::NCH; c++) begin
            if (int'(port) == c && tx_fade_r[c] < alfp_pkg::RELOAD_BELOW) begin
              tx_fade_nxt[c] = alfp_pkg::LOAD_LEVEL;
            end
          end
        end
        alfp_pkg::REQ_RST_BLINK: begin
          rst_fade_nxt = alfp_pkg::LOAD_LEVEL;
        end
        alfp_pkg::REQ_USB_OFF: begin
          rx_fade_nxt[alfp_pkg::NUM_PORTS]  = 16'd0;
          tx_fade_nxt[alfp_pkg::NUM_PORTS]  = 16'd0;
          rx_drive_nxt[alfp_pkg::NUM_PORTS] = 1'b1;
          tx_drive_nxt[alfp_pkg::NUM_PORTS] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      breath_r    <= alfp_pkg::BREATH_START;
      rst_fade_r  <= '0;
      rx_drive_r  <= '0;
      tx_drive_r  <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < alfp_pkg::NCH; c++) begin
        rx_fade_r[c] <= '0;
        tx_fade_r[c] <= '0;
      end
    end else begin
      breath_r    <= breath_nxt;
      rst_fade_r  <= rst_fade_nxt;
      rx_drive_r  <= rx_drive_nxt;
      tx_drive_r  <= tx_drive_nxt;
      out_valid_r <= out_valid_nxt;
      rx_fade_r   <= rx_fade_nxt;
      tx_fade_r   <= tx_fade_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

@@ verif/tb_activity_led_fade_pwm_top.sv @@
// Self-checking testbench for the activity LED fader, with its own model of the fade levels.
`timescale 1ns / 100ps

module tb_activity_led_fade_pwm_top;

  localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [2:0] REQ_SPARE_MID = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI  = 3'd7;
  localparam logic [2:0] PORT_MAX      = 3'd7;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         HOLD_CYCLES   = 250;

  typedef struct packed {
    logic                       power;
    logic [alfp_pkg::LED_W-1:0] rx;
    logic [alfp_pkg::LED_W-1:0] tx;
  } led_frame_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic [2:0]  in_tuser   = 3'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int fail_cnt       = 0;
  int quiet_cycles   = 0;
  bit hold_request   = 1'b0;
  bit hold_taken     = 1'b0;
  int hold_left      = 0;

  alfp_pkg::level_t           breath_lvl;
  alfp_pkg::level_t           button_lvl;
  alfp_pkg::level_t           rx_lvl [alfp_pkg::NCH];
  alfp_pkg::level_t           tx_lvl [alfp_pkg::NCH];
  logic [alfp_pkg::NCH-1:0]   rx_drv;
  logic [alfp_pkg::NCH-1:0]   tx_drv;
  led_frame_t                 tick_leds_q [$];

  activity_led_fade_pwm_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic pwm_on(input alfp_pkg::level_t lvl);
    int peak;
    peak = int'(lvl[15:8]);
    if (peak > 254) peak = 254;
    if (peak > 127) peak = 254 - peak;
    return int'(lvl[7:0]) <= 2 * peak;
  endfunction

  function automatic alfp_pkg::level_t decayed(input alfp_pkg::level_t lvl);
    if (lvl < alfp_pkg::FADE_STEP) return '0;
    return lvl - alfp_pkg::FADE_STEP;
  endfunction

  function automatic void fader_reset();
    breath_lvl = alfp_pkg::BREATH_START;
    button_lvl = '0;
    rx_drv     = '0;
    tx_drv     = '0;
    for (int c = 0; c < alfp_pkg::NCH; c++) begin
      rx_lvl[c] = '0;
      tx_lvl[c] = '0;
    end
  endfunction

  function automatic void fader_apply(input logic [2:0] req, input logic [2:0] prt,
                                      input logic held);
    led_frame_t       frame;
    alfp_pkg::level_t shown;
    case (req)
      alfp_pkg::REQ_TICK: begin
        breath_lvl = breath_lvl + 16'd1;
        if (breath_lvl >= alfp_pkg::BREATH_LIMIT) breath_lvl = alfp_pkg::BREATH_START;
        if (held) begin
          shown      = button_lvl;
          button_lvl = decayed(button_lvl);
        end else begin
          shown = breath_lvl;
        end
        frame.power = pwm_on(shown);
        for (int c = 0; c < alfp_pkg::NCH; c++) begin
          if (rx_lvl[c] != 0) begin
            rx_drv[c] = pwm_on(rx_lvl[c]);
            rx_lvl[c] = decayed(rx_lvl[c]);
          end
          if (tx_lvl[c] != 0) begin
            tx_drv[c] = pwm_on(tx_lvl[c]);
            tx_lvl[c] = decayed(tx_lvl[c]);
          end
        end
        frame.rx = rx_drv[alfp_pkg::LED_W-1:0];
        frame.tx = tx_drv[alfp_pkg::LED_W-1:0];
        tick_leds_q.push_back(frame);
      end
      alfp_pkg::REQ_RX_BLINK: begin
        if (int'(prt) <= alfp_pkg::NUM_PORTS && rx_lvl[prt] < alfp_pkg::RELOAD_BELOW)
          rx_lvl[prt] = alfp_pkg::LOAD_LEVEL;
      end
      alfp_pkg::REQ_TX_BLINK: begin
        if (int'(prt) <= alfp_pkg::NUM_PORTS && tx_lvl[prt] < alfp_pkg::RELOAD_BELOW)
          tx_lvl[prt] = alfp_pkg::LOAD_LEVEL;
      end
      alfp_pkg::REQ_RST_BLINK: begin
        button_lvl = alfp_pkg::LOAD_LEVEL;
      end
      alfp_pkg::REQ_USB_OFF: begin
        rx_lvl[alfp_pkg::NUM_PORTS] = '0;
        tx_lvl[alfp_pkg::NUM_PORTS] = '0;
        rx_drv[alfp_pkg::NUM_PORTS] = 1'b1;
        tx_drv[alfp_pkg::NUM_PORTS] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(input logic [2:0] req, input logic [2:0] prt, input logic held);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0000, held, prt};
    do @(posedge clk); while (!in_tready);
    fader_apply(req, prt, held);
  endtask

  task automatic send_random_item();
    int roll;
    logic [2:0] prt;
    logic held;
    roll = $urandom_range(0, 99);
    prt  = 3'($urandom_range(0, alfp_pkg::NUM_PORTS));
    held = 1'($urandom_range(0, 1));
    if (roll < 55)
      send_beat(alfp_pkg::REQ_TICK, 3'($urandom_range(0, PORT_MAX)), held);
    else if (roll < 67)
      send_beat(alfp_pkg::REQ_RX_BLINK, prt, held);
    else if (roll < 79)
      send_beat(alfp_pkg::REQ_TX_BLINK, prt, held);
    else if (roll < 85)
      send_beat(alfp_pkg::REQ_RST_BLINK, prt, held);
    else if (roll < 90)
      send_beat(alfp_pkg::REQ_USB_OFF, prt, held);
    else if (roll < 95)
      send_beat(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                3'($urandom_range(0, PORT_MAX)), held);
    else
      send_beat(roll[0] ? alfp_pkg::REQ_RX_BLINK : alfp_pkg::REQ_TX_BLINK,
                3'($urandom_range(alfp_pkg::NUM_PORTS + 1, PORT_MAX)), held);
  endtask

  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_beat(alfp_pkg::REQ_TICK, 3'd0, 1'b0);
    send_beat(alfp_pkg::REQ_TICK, PORT_MAX, 1'b1);
    send_beat(alfp_pkg::REQ_RX_BLINK, 3'd0, 1'b0);
    send_beat(alfp_pkg::REQ_TX_BLINK, 3'(alfp_pkg::NUM_PORTS), 1'b1);
    send_beat(alfp_pkg::REQ_RX_BLINK, PORT_MAX, 1'b0);
    send_beat(alfp_pkg::REQ_TX_BLINK, 3'(alfp_pkg::NUM_PORTS + 1), 1'b0);
    send_beat(REQ_SPARE_LO, 3'd2, 1'b1);
    send_beat(REQ_SPARE_MID, 3'd1, 1'b0);
    send_beat(REQ_SPARE_HI, PORT_MAX, 1'b1);
    send_beat(alfp_pkg::REQ_TICK, 3'd3, 1'b0);
    send_beat(alfp_pkg::REQ_RST_BLINK, 3'd0, 1'b0);
    send_beat(alfp_pkg::REQ_TICK, 3'd0, 1'b1);
    send_beat(alfp_pkg::REQ_TICK, 3'd5, 1'b1);
    send_beat(alfp_pkg::REQ_USB_OFF, 3'd0, 1'b0);
    send_beat(alfp_pkg::REQ_TICK, 3'd0, 1'b0);
    send_beat(alfp_pkg::REQ_RX_BLINK, 3'(alfp_pkg::NUM_PORTS), 1'b0);
    send_beat(alfp_pkg::REQ_TICK, 3'd6, 1'b1);
    send_beat(alfp_pkg::REQ_RX_BLINK, 3'd0, 1'b0);
    send_beat(alfp_pkg::REQ_RST_BLINK, 3'd4, 1'b1);
    send_beat(alfp_pkg::REQ_TICK, 3'd0, 1'b0);
    send_beat(alfp_pkg::REQ_TICK, 3'd0, 1'b1);
  endtask

  task automatic test_random_phase(input int items, input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (items) send_random_item();
  endtask

  // The receiver stops for a long stretch while ticks keep coming, so the
  // block has to back-pressure its input.
  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (40)
      send_beat(alfp_pkg::REQ_TICK, 3'($urandom_range(0, PORT_MAX)), 1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    led_frame_t want;
    led_frame_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.power = out_tdata[0];
      got.rx    = out_tdata[5:1];
      got.tx    = out_tdata[10:6];
      if (tick_leds_q.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        fail_cnt++;
      end else begin
        want = tick_leds_q.pop_front();
        if (got.power !== want.power) begin
          $error("power_led: expected %b, got %b", want.power, got.power);
          fail_cnt++;
        end
        if (got.rx !== want.rx) begin
          $error("rx_leds: expected %b, got %b", want.rx, got.rx);
          fail_cnt++;
        end
        if (got.tx !== want.tx) begin
          $error("tx_leds: expected %b, got %b", want.tx, got.tx);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("activity_led_fade_pwm_top verification failed");
      $finish;
    end
  end

  initial begin
    fader_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_output_backpressure();
    test_random_phase(472, 0, 0);
    test_random_phase(472, 62, 0);
    test_random_phase(472, 0, 62);
    test_random_phase(472, 22, 22);
    in_tvalid      <= 1'b0;
    sink_stall_pct = 0;
    while (tick_leds_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0)
      $display("activity_led_fade_pwm_top verification clean");
    else
      $display("activity_led_fade_pwm_top verification failed");
    $finish;
  end

endmodule
